// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// small assertion helpers included by the pose player
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every rising clock edge outside reset
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// implication whose consequent is checked in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ----- rtl/kfpp_pkg.sv -----
// ----------------------------------------------------------------------------
// kfpp_pkg
// shared types, constants and the keyframe rom of the pose player
// ----------------------------------------------------------------------------
package kfpp_pkg;

   localparam int ROM_GESTURES = 12;
   localparam int ROM_KEYS     = 7;
   localparam int ROM_CHANS    = 9;

   localparam int NUM_GESTURES_DEF  = 12;
   localparam int MAX_KEYFRAMES_DEF = 7;
   localparam int NUM_CHANNELS_DEF  = 9;

   localparam logic [1:0] KIND_TICK   = 2'd0;
   localparam logic [1:0] KIND_START  = 2'd1;
   localparam logic [1:0] KIND_CANCEL = 2'd2;

   typedef logic signed [7:0] pose_type;

   // duration of a gesture
   function automatic logic [15:0] rom_dur(input logic [3:0] g);
      logic [15:0] d;
      begin
         case (g)
            4'd0: d = 16'd1000;  4'd1: d = 16'd800;   4'd2: d = 16'd800;
            4'd3: d = 16'd1400;  4'd4: d = 16'd700;   4'd5: d = 16'd1200;
            4'd6: d = 16'd2100;  4'd7: d = 16'd2400;  4'd8: d = 16'd1000;
            4'd9: d = 16'd1000;  4'd10: d = 16'd1700; 4'd11: d = 16'd1400;
            default: d = 16'd0;
         endcase
         return d;
      end
   endfunction

   function automatic logic [3:0] rom_count(input logic [3:0] g);
      logic [3:0] c;
      begin
         case (g)
            4'd1, 4'd8, 4'd9: c = 4'd6;
            4'd2:             c = 4'd5;
            4'd4, 4'd5:       c = 4'd7;
            default:          c = 4'd4;
         endcase
         return c;
      end
   endfunction

   // keyframe time, entries past the count read as zero
   function automatic logic [15:0] rom_at(input logic [3:0] g, input logic [3:0] k);
      logic [15:0] t;
      begin
         t = 16'd0;
         case (g)
            4'd0: case (k) 4'd1: t = 200; 4'd2: t = 600; 4'd3: t = 1000; default: ; endcase
            4'd1: case (k)
                     4'd1: t = 150; 4'd2: t = 300; 4'd3: t = 450; 4'd4: t = 600;
                     4'd5: t = 800; default: ;
                  endcase
            4'd2: case (k)
                     4'd1: t = 200; 4'd2: t = 400; 4'd3: t = 600; 4'd4: t = 800;
                     default: ;
                  endcase
            4'd3: case (k) 4'd1: t = 400; 4'd2: t = 1000; 4'd3: t = 1400; default: ; endcase
            4'd4: case (k)
                     4'd1: t = 100; 4'd2: t = 200; 4'd3: t = 300; 4'd4: t = 400;
                     4'd5: t = 500; 4'd6: t = 700; default: ;
                  endcase
            4'd5: case (k)
                     4'd1: t = 300; 4'd2: t = 500; 4'd3: t = 650; 4'd4: t = 800;
                     4'd5: t = 950; 4'd6: t = 1200; default: ;
                  endcase
            4'd6: case (k) 4'd1: t = 600; 4'd2: t = 1500; 4'd3: t = 2100; default: ; endcase
            4'd7: case (k) 4'd1: t = 800; 4'd2: t = 2000; 4'd3: t = 2400; default: ; endcase
            4'd8, 4'd9: case (k)
                     4'd1: t = 200; 4'd2: t = 400; 4'd3: t = 600; 4'd4: t = 800;
                     4'd5: t = 1000; default: ;
                  endcase
            4'd10: case (k) 4'd1: t = 500; 4'd2: t = 1200; 4'd3: t = 1700; default: ; endcase
            4'd11: case (k) 4'd1: t = 300; 4'd2: t = 1000; 4'd3: t = 1400; default: ; endcase
            default: t = 16'd0;
         endcase
         return t;
      end
   endfunction

   // keyframe pose value for one channel
   function automatic pose_type rom_pose(input logic [3:0] g, input logic [3:0] k,
                                         input logic [3:0] c);
      logic [8:0][7:0] r;
      begin
         r = '0;
         case (g)
            4'd0: case (k)
                     4'd1: r = {8'sd0, 8'sd0, 8'sd0, -8'sd10, 8'sd10, 8'sd0, 8'sd0, 8'sd15, 8'sd0};
                     4'd2: r = {8'sd0, 8'sd0, 8'sd0, -8'sd15, 8'sd15, 8'sd0, 8'sd0, 8'sd20, 8'sd0};
                     default: ;
                  endcase
            4'd1: case (k)
                     4'd0: r = {8'sd0, -8'sd15, -8'sd15, 8'sd0, 8'sd0, 8'sd0, 8'sd0, 8'sd0, 8'sd0};
                     4'd1: r = {8'sd0, -8'sd20, -8'sd20, -8'sd5, 8'sd5, 8'sd0, 8'sd0, -8'sd5, 8'sd0};
                     4'd2: r = {8'sd0, -8'sd15, -8'sd15, -8'sd8, 8'sd8, 8'sd0, 8'sd0, 8'sd5, 8'sd0};
                     4'd3: r = {8'sd0, -8'sd20, -8'sd20, -8'sd5, 8'sd5, 8'sd0, 8'sd0, -8'sd3, 8'sd0};
                     4'd4: r = {8'sd0, -8'sd15, -8'sd15, 8'sd0, 8'sd0, 8'sd0, 8'sd0, 8'sd0, 8'sd0};
                     default: ;
                  endcase
            4'd2: case (k)
                     4'd1: r = {8'sd0, -8'sd5, 8'sd10, 8'sd0, 8'sd0, 8'sd0, 8'sd0, 8'sd0, -8'sd15};
                     4'd2: r = {8'sd0, 8'sd10, -8'sd5, 8'sd0, 8'sd0, 8'sd0, 8'sd0, 8'sd0, 8'sd15};
                     4'd3: r = {8'sd0, -8'sd5, 8'sd10, 8'sd0, 8'sd0, 8'sd0, 8'sd0, 8'sd0, -8'sd10};
                     default: ;
                  endcase
            4'd3: case (k)
                     4'd1, 4'd2:
                        r = {8'sd0, 8'sd8, 8'sd5, 8'sd5, -8'sd10, 8'sd0, 8'sd0, 8'sd10, -8'sd20};
                     default: ;
                  endcase
            4'd4: case (k)
                     4'd1: r = {8'sd0, -8'sd20, -8'sd20, -8'sd15, 8'sd15, 8'sd0, 8'sd0, -8'sd10, -8'sd10};
                     4'd2: r = {8'sd0, -8'sd18, -8'sd18, -8'sd12, 8'sd12, 8'sd0, 8'sd0, -8'sd8, 8'sd10};
                     4'd3: r = {8'sd0, -8'sd20, -8'sd20, -8'sd15, 8'sd15, 8'sd0, 8'sd0, -8'sd10, -8'sd8};
                     4'd4: r = {8'sd0, -8'sd18, -8'sd18, -8'sd12, 8'sd12, 8'sd0, 8'sd0, -8'sd8, 8'sd8};
                     4'd5: r = {8'sd0, -8'sd15, -8'sd15, -8'sd10, 8'sd10, 8'sd0, 8'sd0, 8'sd0, 8'sd0};
                     default: ;
                  endcase
            4'd5: case (k)
                     4'd1, 4'd3, 4'd5: r = {8'sd30, 64'd0};
                     4'd2, 4'd4:       r = {8'sd40, 64'd0};
                     default: ;
                  endcase
            4'd6: case (k)
                     4'd1, 4'd2:
                        r = {8'sd0, 8'sd15, 8'sd15, 8'sd10, -8'sd10, 8'sd0, 8'sd0, 8'sd20, 8'sd0};
                     default: ;
                  endcase
            4'd7: case (k)
                     4'd1, 4'd2:
                        r = {8'sd0, -8'sd10, -8'sd10, -8'sd20, 8'sd20, 8'sd0, 8'sd0, -8'sd25, 8'sd0};
                     default: ;
                  endcase
            4'd8: case (k)
                     4'd1: r = {8'sd0, 48'd0, -8'sd15, 8'sd0};
                     4'd2: r = {8'sd0, 48'd0, 8'sd15, 8'sd0};
                     4'd3: r = {8'sd0, 48'd0, -8'sd10, 8'sd0};
                     4'd4: r = {8'sd0, 48'd0, 8'sd10, 8'sd0};
                     default: ;
                  endcase
            4'd9: case (k)
                     4'd1: r = {64'd0, -8'sd20};
                     4'd2: r = {64'd0, 8'sd20};
                     4'd3: r = {64'd0, -8'sd15};
                     4'd4: r = {64'd0, 8'sd15};
                     default: ;
                  endcase
            4'd10: case (k)
                     4'd1, 4'd2:
                        r = {8'sd0, -8'sd8, -8'sd8, -8'sd10, 8'sd10, 8'sd0, 8'sd0, -8'sd10, 8'sd0};
                     default: ;
                  endcase
            4'd11: case (k)
                     4'd1, 4'd2:
                        r = {8'sd0, -8'sd15, -8'sd15, 8'sd15, -8'sd15, 8'sd0, 8'sd0, 8'sd15, 8'sd0};
                     default: ;
                  endcase
            default: ;
         endcase
         return (c < 4'd9) ? pose_type'(r[c]) : pose_type'(0);
      end
   endfunction

   // sequencer request to the divider
   typedef struct packed {
      logic               start;
      logic signed [23:0] num;   // (b-a)*256*m, fits 24 bits signed
      logic [15:0]        den;
   } div_req_type;

   typedef struct packed {
      logic               done;
      logic signed [23:0] quo;
   } div_rsp_type;

endpackage

// ----- rtl/keyframe_servo_pose_player.sv -----
// ----------------------------------------------------------------------------
// keyframe_servo_pose_player
// plays built-in keyframe animations by linear interpolation of servo offsets
// ----------------------------------------------------------------------------
// one item in, one item out. a tick while playing ends the gesture once its
// duration has passed; else it searches the keyframe segments one per cycle,
// at most MAX_KEYFRAMES-1 of them, then runs each channel through the shared
// 24-step divider. the divider sets the rate; req_tready is low from
// acceptance until the result item has been taken.
module keyframe_servo_pose_player #(
   parameter int NUM_GESTURES  = kfpp_pkg::NUM_GESTURES_DEF,
   parameter int MAX_KEYFRAMES = kfpp_pkg::MAX_KEYFRAMES_DEF,
   parameter int NUM_CHANNELS  = kfpp_pkg::NUM_CHANNELS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [39:0]  req_tdata,   // gesture_id[3:0], now_ms[35:4], zero fill
   input  logic [1:0]   req_tuser,   // kind[1:0]
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [167:0] rsp_tdata    // playing[0], duration_ms[16:1], offset_0..8, zero fill
);
`include "assert_macros.svh"
   import kfpp_pkg::*;

   typedef enum logic [2:0] {S_IDLE, S_SEARCH, S_SETUP, S_DIV, S_OUT} state_type;

   state_type          state_ff;
   logic               active_ff;
   logic [3:0]         gesture_ff;
   logic [31:0]        start_ff;
   logic [8:0][15:0]   offs_ff;
   logic [31:0]        elapsed_ff;
   logic [3:0]         seg_ff;       // search index and later first key
   logic [3:0]         chan_ff;
   logic [15:0]        dur_ff;
   logic [15:0]        len_ff;
   logic [15:0]        m_ff;
   div_req_type        dreq;
   div_rsp_type        drsp;

   logic [3:0]  nkeys;
   logic [15:0] at_p, at_q, seg_len;
   logic [31:0] fe;
   logic signed [8:0]  diff;
   logic signed [23:0] prod;
   pose_type    pa, pb;
   logic [3:0]  nxt;
   logic        start_ok;

   kfpp_divider u_div (.clock(clock), .reset(reset), .req(dreq), .rsp(drsp));

   always_comb begin
      nkeys = rom_count(gesture_ff);
      if ({1'b0, nkeys} > 5'(MAX_KEYFRAMES)) nkeys = 4'(MAX_KEYFRAMES);
      if (nkeys < 4'd2) nkeys = 4'd2;
      // start item with a gesture that exists
      start_ok = (req_tuser == KIND_START) &&
                 ({1'b0, req_tdata[3:0]} < 5'(NUM_GESTURES)) &&
                 ({1'b0, req_tdata[3:0]} < 5'(ROM_GESTURES));
      nxt  = seg_ff + 4'd1;
      at_p = rom_at(gesture_ff, seg_ff);
      at_q = rom_at(gesture_ff, nxt);
      seg_len = at_q - at_p;
      fe   = elapsed_ff - {16'd0, at_p};
      pa   = rom_pose(gesture_ff, seg_ff, chan_ff);
      pb   = rom_pose(gesture_ff, nxt, chan_ff);
      diff = 9'(pb) - 9'(pa);
      // (b-a)*256*m: |b-a|<=256, m<=2400; the rom values keep it within 24 bits
      prod = 24'(diff * $signed({1'b0, m_ff})) <<< 8;
      dreq.start = (state_ff == S_SETUP);
      dreq.num   = prod;
      dreq.den   = len_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         active_ff  <= 1'b0;
         gesture_ff <= '0;
         start_ff   <= '0;
         offs_ff    <= '0;
      end else begin
         case (state_ff)
            S_IDLE: if (req_tvalid) begin
               dur_ff <= start_ok ? rom_dur(req_tdata[3:0]) : 16'd0;
               case (req_tuser)
                  KIND_TICK: if (active_ff) begin
                     elapsed_ff <= req_tdata[35:4] - start_ff;
                     seg_ff     <= '0;
                  end
                  KIND_START: if (start_ok) begin
                     active_ff  <= 1'b1;
                     gesture_ff <= req_tdata[3:0];
                     start_ff   <= req_tdata[35:4];
                  end
                  KIND_CANCEL: if (active_ff) begin
                     active_ff <= 1'b0;
                     offs_ff   <= '0;
                  end
                  default: ;
               endcase
               state_ff <= (req_tuser == KIND_TICK && active_ff) ? S_SEARCH : S_OUT;
            end
            S_SEARCH: begin
               if (elapsed_ff >= {16'd0, rom_dur(gesture_ff)}) begin
                  active_ff <= 1'b0;
                  offs_ff   <= '0;
                  state_ff  <= S_OUT;
               end else if (elapsed_ff >= {16'd0, at_p} && elapsed_ff < {16'd0, at_q}) begin
                  len_ff   <= (seg_len == 16'd0) ? 16'd1 : seg_len;
                  m_ff     <= (fe < {16'd0, seg_len}) ? fe[15:0] : seg_len;
                  chan_ff  <= '0;
                  state_ff <= S_SETUP;
               end else if (nxt + 4'd1 >= nkeys) begin
                  // no segment holds the time: first pair
                  seg_ff   <= '0;
                  len_ff   <= (rom_at(gesture_ff, 4'd1) == 16'd0) ? 16'd1
                              : rom_at(gesture_ff, 4'd1);
                  m_ff     <= (elapsed_ff < {16'd0, rom_at(gesture_ff, 4'd1)})
                              ? elapsed_ff[15:0] : rom_at(gesture_ff, 4'd1);
                  chan_ff  <= '0;
                  state_ff <= S_SETUP;
               end else begin
                  seg_ff <= nxt;
               end
            end
            S_SETUP: begin
               if (m_ff == 16'd0 && len_ff == 16'd0) m_ff <= '0;
               state_ff <= S_DIV;
            end
            S_DIV: if (drsp.done) begin
               offs_ff[chan_ff] <= 16'({pa, 8'd0} + drsp.quo);
               chan_ff  <= chan_ff + 4'd1;
               state_ff <= (chan_ff + 4'd1 >= 4'(NUM_CHANNELS)) ? S_OUT : S_SETUP;
            end
            S_OUT: if (rsp_tready) state_ff <= S_IDLE;
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = (state_ff == S_OUT);
   assign rsp_tdata  = {7'd0, offs_ff, dur_ff, active_ff};

   `ASSERT_IMPLY(a_idle_clear, clock, reset, rsp_tvalid && !active_ff, offs_ff == '0)
   `ASSERT_NEXT(a_hold_out, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid)
   `ASSERT_IMPLY(a_no_overlap, clock, reset, req_tready, !rsp_tvalid)

endmodule

// ----- rtl/kfpp_divider.sv -----
// ----------------------------------------------------------------------------
// kfpp_divider
// shared restoring divider, one quotient bit per cycle, truncates toward zero
// ----------------------------------------------------------------------------
module kfpp_divider (
   input  logic                 clock,
   input  logic                 reset,
   input  kfpp_pkg::div_req_type req,
   output kfpp_pkg::div_rsp_type rsp
);
   import kfpp_pkg::*;

   logic [23:0] rem_ff, rem_in;
   logic [23:0] quo_ff, quo_in;
   logic [15:0] den_ff, den_in;
   logic        neg_ff, neg_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [24:0] trial;
   logic [23:0] mag;

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      mag     = req.num[23] ? 24'(-req.num) : 24'(req.num);
      trial   = {rem_ff, quo_ff[23]} - {9'd0, den_ff};
      if (req.start) begin
         rem_in  = '0;
         quo_in  = mag;
         den_in  = req.den;
         neg_in  = req.num[23];
         cnt_in  = 5'd0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // shift one dividend bit into the remainder
         if (!trial[24]) begin
            rem_in = trial[23:0];
            quo_in = {quo_ff[22:0], 1'b1};
         end else begin
            rem_in = {rem_ff[22:0], quo_ff[23]};
            quo_in = {quo_ff[22:0], 1'b0};
         end
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'd23) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
      neg_ff <= neg_in;
   end

   assign rsp.done = done_ff;
   assign rsp.quo  = neg_ff ? -$signed(quo_ff) : $signed(quo_ff);

endmodule

// ----- bench/keyframe_servo_pose_player_tb.sv -----
// ----------------------------------------------------------------------------
// keyframe_servo_pose_player_tb
// self-checking bench for the keyframe pose player: items are sent through
// the request stream, each result item is compared field by field against a
// behavioural player kept inside the bench, with random stalls on both sides
// ----------------------------------------------------------------------------
module keyframe_servo_pose_player_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import kfpp_pkg::*;

   localparam logic [1:0] KIND_SPARE = 2'd3;   // unused kind, reports status only
   localparam int         STALL_LIMIT = 5000;  // cycles without any handshake
   localparam int         QUIET_FROM  = 760;   // items after which nobody idles

   // laid out as on rsp_tdata, playing in the lowest bit
   typedef struct packed {
      logic [8:0][15:0]       offsets;
      logic [15:0]            duration;
      logic                   playing;
   } pose_result_type;

   logic          clock;
   logic          reset;
   logic          req_tvalid;
   logic          req_tready;
   logic [39:0]   req_tdata;   // gesture_id[3:0], now_ms[35:4], zero fill
   logic [1:0]    req_tuser;   // kind[1:0]
   logic          rsp_tvalid;
   logic          rsp_tready;
   logic [167:0]  rsp_tdata;   // playing[0], duration_ms[16:1], offset_0..8, zero fill

   keyframe_servo_pose_player DUT (
      .clock                   (clock),
      .reset                   (reset),
      .req_tvalid              (req_tvalid),
      .req_tready              (req_tready),
      .req_tdata               (req_tdata),
      .req_tuser               (req_tuser),
      .rsp_tvalid              (rsp_tvalid),
      .rsp_tready              (rsp_tready),
      .rsp_tdata               (rsp_tdata)
   );

   // ------------------------------------------------------------------------
   // keyframe tables of the twelve gestures
   // ------------------------------------------------------------------------
   int anim_dur [12] = '{1000, 800, 800, 1400, 700, 1200, 2100, 2400, 1000, 1000, 1700, 1400};
   int anim_keys[12] = '{4, 6, 5, 4, 7, 7, 4, 4, 6, 6, 4, 4};
   int anim_at  [12][7] = '{
      '{0, 200, 600, 1000, 0, 0, 0},
      '{0, 150, 300, 450, 600, 800, 0},
      '{0, 200, 400, 600, 800, 0, 0},
      '{0, 400, 1000, 1400, 0, 0, 0},
      '{0, 100, 200, 300, 400, 500, 700},
      '{0, 300, 500, 650, 800, 950, 1200},
      '{0, 600, 1500, 2100, 0, 0, 0},
      '{0, 800, 2000, 2400, 0, 0, 0},
      '{0, 200, 400, 600, 800, 1000, 0},
      '{0, 200, 400, 600, 800, 1000, 0},
      '{0, 500, 1200, 1700, 0, 0, 0},
      '{0, 300, 1000, 1400, 0, 0, 0}};
   int anim_pose[12][7][9];

   task automatic set_pose(input int g, input int k, input int v[9]);
      for (int c = 0; c < 9; c++) anim_pose[g][k][c] = v[c];
   endtask

   task automatic load_poses();
      foreach (anim_pose[g, k, c]) anim_pose[g][k][c] = 0;
      set_pose(0, 1, '{0, 15, 0, 0, 10, -10, 0, 0, 0});
      set_pose(0, 2, '{0, 20, 0, 0, 15, -15, 0, 0, 0});
      set_pose(1, 0, '{0, 0, 0, 0, 0, 0, -15, -15, 0});
      set_pose(1, 1, '{0, -5, 0, 0, 5, -5, -20, -20, 0});
      set_pose(1, 2, '{0, 5, 0, 0, 8, -8, -15, -15, 0});
      set_pose(1, 3, '{0, -3, 0, 0, 5, -5, -20, -20, 0});
      set_pose(1, 4, '{0, 0, 0, 0, 0, 0, -15, -15, 0});
      set_pose(2, 1, '{-15, 0, 0, 0, 0, 0, 10, -5, 0});
      set_pose(2, 2, '{15, 0, 0, 0, 0, 0, -5, 10, 0});
      set_pose(2, 3, '{-10, 0, 0, 0, 0, 0, 10, -5, 0});
      set_pose(3, 1, '{-20, 10, 0, 0, -10, 5, 5, 8, 0});
      set_pose(3, 2, '{-20, 10, 0, 0, -10, 5, 5, 8, 0});
      set_pose(4, 1, '{-10, -10, 0, 0, 15, -15, -20, -20, 0});
      set_pose(4, 2, '{10, -8, 0, 0, 12, -12, -18, -18, 0});
      set_pose(4, 3, '{-8, -10, 0, 0, 15, -15, -20, -20, 0});
      set_pose(4, 4, '{8, -8, 0, 0, 12, -12, -18, -18, 0});
      set_pose(4, 5, '{0, 0, 0, 0, 10, -10, -15, -15, 0});
      set_pose(5, 1, '{0, 0, 0, 0, 0, 0, 0, 0, 30});
      set_pose(5, 2, '{0, 0, 0, 0, 0, 0, 0, 0, 40});
      set_pose(5, 3, '{0, 0, 0, 0, 0, 0, 0, 0, 30});
      set_pose(5, 4, '{0, 0, 0, 0, 0, 0, 0, 0, 40});
      set_pose(5, 5, '{0, 0, 0, 0, 0, 0, 0, 0, 30});
      set_pose(6, 1, '{0, 20, 0, 0, -10, 10, 15, 15, 0});
      set_pose(6, 2, '{0, 20, 0, 0, -10, 10, 15, 15, 0});
      set_pose(7, 1, '{0, -25, 0, 0, 20, -20, -10, -10, 0});
      set_pose(7, 2, '{0, -25, 0, 0, 20, -20, -10, -10, 0});
      set_pose(8, 1, '{0, -15, 0, 0, 0, 0, 0, 0, 0});
      set_pose(8, 2, '{0, 15, 0, 0, 0, 0, 0, 0, 0});
      set_pose(8, 3, '{0, -10, 0, 0, 0, 0, 0, 0, 0});
      set_pose(8, 4, '{0, 10, 0, 0, 0, 0, 0, 0, 0});
      set_pose(9, 1, '{-20, 0, 0, 0, 0, 0, 0, 0, 0});
      set_pose(9, 2, '{20, 0, 0, 0, 0, 0, 0, 0, 0});
      set_pose(9, 3, '{-15, 0, 0, 0, 0, 0, 0, 0, 0});
      set_pose(9, 4, '{15, 0, 0, 0, 0, 0, 0, 0, 0});
      set_pose(10, 1, '{0, -10, 0, 0, 10, -10, -8, -8, 0});
      set_pose(10, 2, '{0, -10, 0, 0, 10, -10, -8, -8, 0});
      set_pose(11, 1, '{0, 15, 0, 0, -15, 15, -15, -15, 0});
      set_pose(11, 2, '{0, 15, 0, 0, -15, 15, -15, -15, 0});
   endtask

   // ------------------------------------------------------------------------
   // player state as the bench sees it
   // ------------------------------------------------------------------------
   logic                pl_active;
   logic [3:0]          pl_gesture;
   logic [31:0]         pl_start;
   logic signed [15:0]  pl_offsets [9];

   pose_result_type     pending_poses [$];
   int                  mismatches;
   int                  items_sent;
   bit                  quiet;

   // interpolate the pose of the running gesture at time now
   task automatic advance_pose(input logic [31:0] now);
      logic [31:0] elapsed;
      logic [31:0] fe;
      int          n, p, q, len, m, a, b;
      if (!pl_active) return;
      elapsed = now - pl_start;
      if (elapsed >= 32'(anim_dur[pl_gesture])) begin
         pl_active = 1'b0;
         foreach (pl_offsets[c]) pl_offsets[c] = '0;
         return;
      end
      n = anim_keys[pl_gesture];
      p = 0;
      q = 1;
      for (int i = 0; i + 1 < n; i++) begin
         if (elapsed >= 32'(anim_at[pl_gesture][i]) && elapsed < 32'(anim_at[pl_gesture][i+1])) begin
            p = i;
            q = i + 1;
            break;
         end
      end
      len = anim_at[pl_gesture][q] - anim_at[pl_gesture][p];
      if (len == 0) len = 1;
      fe = elapsed - 32'(anim_at[pl_gesture][p]);
      m  = (fe < 32'(len)) ? int'(fe) : len;
      for (int c = 0; c < 9; c++) begin
         a = anim_pose[pl_gesture][p][c];
         b = anim_pose[pl_gesture][q][c];
         pl_offsets[c] = 16'(a * 256 + ((b - a) * 256 * m) / len);
      end
   endtask

   task automatic predict_pose(input logic [1:0] kind, input logic [3:0] gid,
                               input logic [31:0] now);
      pose_result_type r;
      r.duration = '0;
      case (kind)
         KIND_TICK: advance_pose(now);
         KIND_START: begin
            if (gid < 4'd12) begin
               pl_active  = 1'b1;
               pl_gesture = gid;
               pl_start   = now;
               r.duration = 16'(anim_dur[gid]);
            end
         end
         KIND_CANCEL: begin
            if (pl_active) begin
               pl_active = 1'b0;
               foreach (pl_offsets[c]) pl_offsets[c] = '0;
            end
         end
         default: ;
      endcase
      r.playing = pl_active;
      for (int c = 0; c < 9; c++) r.offsets[c] = pl_offsets[c];
      pending_poses.push_back(r);
   endtask

   // ------------------------------------------------------------------------
   // clock, reset and watchdog
   // ------------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   int idle_cycles;
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------------------
   // result side: random back-pressure, then check against the oldest pose
   // ------------------------------------------------------------------------
   initial begin
      rsp_tready = 1'b0;
      @(posedge clock);
      forever begin
         if (quiet || $urandom_range(0, 2) != 0) begin
            rsp_tready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge clock);
         end else begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      pose_result_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata[160:0];
         if (pending_poses.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result item %h", got);
         end else begin
            want = pending_poses.pop_front();
            if (got.playing !== want.playing || got.duration !== want.duration ||
                got.offsets !== want.offsets) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected playing %b dur %0d offs %h, got %b %0d %h",
                           want.playing, want.duration, want.offsets,
                           got.playing, got.duration, got.offsets);
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // request side
   // ------------------------------------------------------------------------
   // one item; valid is only lowered when a gap is inserted, so that it is
   // never dropped and raised within the same step
   task automatic send_item(input logic [1:0] kind, input logic [3:0] gid,
                            input logic [31:0] now);
      int gap;
      gap = (!quiet && $urandom_range(0, 3) == 0) ? $urandom_range(1, 11) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {4'd0, now, gid};
      do @(posedge clock); while (!req_tready);
      predict_pose(kind, gid, now);
      items_sent++;
      if (items_sent >= QUIET_FROM) quiet = 1'b1;
   endtask

   // sender holds off until every pose has come back
   task automatic drain_poses();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_poses.size() != 0) @(posedge clock);
   endtask

   // tick, cancel and the spare kind while idle, right after reset
   task automatic test_idle_items();
      send_item(KIND_TICK, 4'd0, 32'd0);
      send_item(KIND_CANCEL, 4'd15, 32'hFFFF_FFFF);
      send_item(KIND_SPARE, 4'd5, 32'h1234_5678);
      send_item(KIND_TICK, 4'd15, 32'hFFFF_FFFF);
   endtask

   // out-of-range gestures leave everything alone, also while a valid gesture plays
   task automatic test_invalid_gestures();
      for (int g = 12; g < 16; g++) send_item(KIND_START, 4'(g), $urandom());
      send_item(KIND_START, 4'd3, 32'd100);
      send_item(KIND_START, 4'd13, 32'd0);
      send_item(KIND_TICK, 4'd0, 32'd500);
   endtask

   // each gesture once, on its first keyframe, at a random time, just before and at its end
   task automatic test_every_gesture();
      for (int g = 0; g < 12; g++) begin
         send_item(KIND_START, 4'(g), 32'd5000);
         send_item(KIND_TICK, 4'd0, 32'd5000 + 32'(anim_at[g][1]));
         send_item(KIND_TICK, 4'd0, 32'd5000 + 32'($urandom_range(0, anim_dur[g] - 1)));
         send_item(KIND_TICK, 4'd0, 32'd5000 + 32'(anim_dur[g] - 1));
         send_item(KIND_TICK, 4'd0, 32'd5000 + 32'(anim_dur[g]));
      end
   endtask

   // time wrap, restart while playing, cancel and the spare kind while playing
   task automatic test_timing_edges();
      send_item(KIND_START, 4'd4, 32'hFFFF_FF80);
      send_item(KIND_TICK, 4'd0, 32'h0000_0040);
      send_item(KIND_SPARE, 4'd0, 32'd0);
      send_item(KIND_START, 4'd11, 32'h0000_0100);
      send_item(KIND_TICK, 4'd0, 32'h0000_0100);
      send_item(KIND_CANCEL, 4'd0, 32'd0);
      send_item(KIND_TICK, 4'd0, 32'h0000_0200);
      send_item(KIND_START, 4'd7, 32'h8000_0000);
      send_item(KIND_TICK, 4'd0, 32'h7FFF_FFFF);
   endtask

   // plays with random content, with cancels, restarts and noise in between
   task automatic test_random_play();
      logic [31:0] base, now;
      int          g, ticks, pick;
      while (items_sent < 850) begin
         g    = $urandom_range(0, 11);
         base = ($urandom_range(0, 4) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 3000)
                                            : $urandom();
         send_item(KIND_START, 4'(g), base);
         now   = base;
         ticks = $urandom_range(3, 12);
         for (int t = 0; t < ticks; t++) begin
            pick = $urandom_range(0, 99);
            if (pick < 4) begin
               send_item(KIND_CANCEL, 4'($urandom()), $urandom());
            end else if (pick < 8) begin
               send_item(KIND_SPARE, 4'($urandom()), $urandom());
            end else if (pick < 12) begin
               send_item(KIND_START, 4'($urandom_range(12, 15)), $urandom());
            end else if (pick < 16) begin
               send_item(KIND_TICK, 4'($urandom()), $urandom());
            end else begin
               now = now + $urandom_range(0, anim_dur[g] / 4);
               send_item(KIND_TICK, 4'($urandom()), now);
            end
         end
         if (items_sent > 400 && items_sent < 420) drain_poses();
      end
   endtask

   initial begin
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tuser   = '0;
      req_tdata   = '0;
      mismatches  = 0;
      items_sent  = 0;
      quiet       = 1'b0;
      pl_active   = 1'b0;
      pl_gesture  = '0;
      pl_start    = '0;
      foreach (pl_offsets[c]) pl_offsets[c] = '0;
      load_poses();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_idle_items();
      test_invalid_gestures();
      test_every_gesture();
      drain_poses();
      test_timing_edges();
      test_random_play();

      req_tvalid <= 1'b0;
      while (pending_poses.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
      if (mismatches == 0 && pending_poses.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/kfpp_pkg.sv
rtl/kfpp_divider.sv
rtl/keyframe_servo_pose_player.sv
bench/keyframe_servo_pose_player_tb.sv
